// File: rtl/rcsp_pkg.sv
// Shared types and constants for the run-length chunk stream parser.
`timescale 1ns / 1ps

package rcsp_pkg;

    // Header layout
    localparam logic [3:0]  HDR_LEN_C = 4'd12;

    // Header constant bytes: four-character code and format tag
    localparam logic [7:0] MAGIC_0    = 8'h53;   // 'S'
    localparam logic [7:0] MAGIC_1    = 8'h4D;   // 'M'
    localparam logic [7:0] MAGIC_2    = 8'h43;   // 'C'
    localparam logic [7:0] MAGIC_3    = 8'h44;   // 'D'
    localparam logic [7:0] FORMAT_TAG = 8'h52;   // 'R'

    // Header byte positions that carry a check
    localparam logic [3:0] POS_MAGIC_0 = 4'd0;
    localparam logic [3:0] POS_MAGIC_1 = 4'd1;
    localparam logic [3:0] POS_MAGIC_2 = 4'd2;
    localparam logic [3:0] POS_MAGIC_3 = 4'd3;
    localparam logic [3:0] POS_VERSION = 4'd4;
    localparam logic [3:0] POS_BITS_X  = 4'd5;
    localparam logic [3:0] POS_BITS_Y  = 4'd6;
    localparam logic [3:0] POS_BITS_Z  = 4'd7;
    localparam logic [3:0] POS_FORMAT  = 4'd11;

    // Saturation limit of the running block total
    localparam logic [16:0] TOTAL_MAX = 17'h1FFFF;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_VERSION = 3'd0,
        CFG_BITS_X  = 3'd1,
        CFG_BITS_Y  = 3'd2,
        CFG_BITS_Z  = 3'd3,
        CFG_TOTAL   = 3'd4
    } cfg_index_t;

    // Status codes of the final record
    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_CODE    = 4'd1,
        ST_VERSION = 4'd2,
        ST_BITS_X  = 4'd3,
        ST_BITS_Y  = 4'd4,
        ST_BITS_Z  = 4'd5,
        ST_FORMAT  = 4'd6,
        ST_COUNT   = 4'd7,
        ST_LENGTH  = 4'd8
    } status_t;

    // Record kinds
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One result record
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  block_type;
        logic [16:0] start_index;
        logic [7:0]  run_length;
        status_t     status;
        logic        final_flag;
    } rec_t;

    // Records produced by one input byte (count is 0, 1 or 2)
    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } rec_pair_t;

endpackage

// File: rtl/rcsp_parser.sv
// Parser state, configuration registers and per-byte record generation.
`timescale 1ns / 1ps

module rcsp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output rcsp_pkg::rec_pair_t recs
);

    // Configuration registers
    logic [7:0]  exp_version_reg;
    logic [3:0]  exp_bits_x_reg;
    logic [3:0]  exp_bits_y_reg;
    logic [3:0]  exp_bits_z_reg;
    logic [16:0] exp_total_reg;

    // Parse state
    logic [3:0]  hdr_pos_reg,   hdr_pos_next;
    logic [3:0]  hdr_err_reg,   hdr_err_next;
    logic        phase_reg,     phase_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [16:0] total_reg,     total_next;

    // Working values for the current byte
    logic        in_header;
    logic [3:0]  byte_err;
    logic [3:0]  err_upd;
    logic [3:0]  pos_upd;
    logic        phase_upd;
    logic [7:0]  type_upd;
    logic [16:0] total_upd;
    logic [17:0] total_sum;
    logic        run_emit;
    rcsp_pkg::status_t final_status;
    rcsp_pkg::rec_t    run_rec;
    rcsp_pkg::rec_t    stat_rec;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= 8'd1;
            exp_bits_x_reg  <= 4'd4;
            exp_bits_y_reg  <= 4'd4;
            exp_bits_z_reg  <= 4'd8;
            exp_total_reg   <= 17'h10000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcsp_pkg::CFG_VERSION: exp_version_reg <= cfg_data[7:0];
                rcsp_pkg::CFG_BITS_X:  exp_bits_x_reg  <= cfg_data[3:0];
                rcsp_pkg::CFG_BITS_Y:  exp_bits_y_reg  <= cfg_data[3:0];
                rcsp_pkg::CFG_BITS_Z:  exp_bits_z_reg  <= cfg_data[3:0];
                rcsp_pkg::CFG_TOTAL:   exp_total_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Header byte check by position
    always_comb
    begin
        byte_err = rcsp_pkg::ST_OK;
        unique case (hdr_pos_reg)
            rcsp_pkg::POS_MAGIC_0:
                if (in_byte != rcsp_pkg::MAGIC_0) byte_err = rcsp_pkg::ST_CODE;
            rcsp_pkg::POS_MAGIC_1:
                if (in_byte != rcsp_pkg::MAGIC_1) byte_err = rcsp_pkg::ST_CODE;
            rcsp_pkg::POS_MAGIC_2:
                if (in_byte != rcsp_pkg::MAGIC_2) byte_err = rcsp_pkg::ST_CODE;
            rcsp_pkg::POS_MAGIC_3:
                if (in_byte != rcsp_pkg::MAGIC_3) byte_err = rcsp_pkg::ST_CODE;
            rcsp_pkg::POS_VERSION:
                if (in_byte != exp_version_reg) byte_err = rcsp_pkg::ST_VERSION;
            rcsp_pkg::POS_BITS_X:
                if (in_byte != {4'd0, exp_bits_x_reg}) byte_err = rcsp_pkg::ST_BITS_X;
            rcsp_pkg::POS_BITS_Y:
                if (in_byte != {4'd0, exp_bits_y_reg}) byte_err = rcsp_pkg::ST_BITS_Y;
            rcsp_pkg::POS_BITS_Z:
                if (in_byte != {4'd0, exp_bits_z_reg}) byte_err = rcsp_pkg::ST_BITS_Z;
            rcsp_pkg::POS_FORMAT:
                if (in_byte != rcsp_pkg::FORMAT_TAG) byte_err = rcsp_pkg::ST_FORMAT;
            default: byte_err = rcsp_pkg::ST_OK;
        endcase
    end

    // Saturating add of the pair count
    assign total_sum = {1'b0, total_reg} + {10'd0, in_byte};

    // State update for one byte, before the end-of-file clear
    always_comb
    begin
        in_header = (hdr_pos_reg < rcsp_pkg::HDR_LEN_C);
        err_upd   = hdr_err_reg;
        pos_upd   = hdr_pos_reg;
        phase_upd = phase_reg;
        type_upd  = held_type_reg;
        total_upd = total_reg;
        run_emit  = 1'b0;
        if (in_header)
        begin
            if (hdr_err_reg == rcsp_pkg::ST_OK)
                err_upd = byte_err;
            pos_upd = hdr_pos_reg + 4'd1;
        end
        else if (!phase_reg)
        begin
            type_upd  = in_byte;
            phase_upd = 1'b1;
        end
        else
        begin
            phase_upd = 1'b0;
            if (in_byte != 8'd0)
            begin
                run_emit  = (hdr_err_reg == rcsp_pkg::ST_OK);
                total_upd = total_sum[17] ? rcsp_pkg::TOTAL_MAX : total_sum[16:0];
            end
        end
    end

    // Final status, first matching cause wins
    always_comb
    begin
        priority if (err_upd != rcsp_pkg::ST_OK)
            final_status = rcsp_pkg::status_t'(err_upd);
        else if (pos_upd < rcsp_pkg::HDR_LEN_C || phase_upd)
            final_status = rcsp_pkg::ST_LENGTH;
        else if (total_upd != exp_total_reg)
            final_status = rcsp_pkg::ST_COUNT;
        else
            final_status = rcsp_pkg::ST_OK;
    end

    // Record assembly
    always_comb
    begin
        run_rec.result_kind  = rcsp_pkg::KIND_RUN;
        run_rec.block_type   = held_type_reg;
        run_rec.start_index  = total_reg;
        run_rec.run_length   = in_byte;
        run_rec.status       = rcsp_pkg::ST_OK;
        run_rec.final_flag   = 1'b0;

        stat_rec.result_kind = rcsp_pkg::KIND_STATUS;
        stat_rec.block_type  = 8'd0;
        stat_rec.start_index = 17'd0;
        stat_rec.run_length  = 8'd0;
        stat_rec.status      = final_status;
        stat_rec.final_flag  = 1'b1;

        recs.rec0  = run_emit ? run_rec : stat_rec;
        recs.rec1  = stat_rec;
        recs.count = 2'd0;
        if (in_accept)
            recs.count = {1'b0, run_emit} + {1'b0, in_last};
    end

    // Next state: end of file clears the parse state
    always_comb
    begin
        hdr_pos_next   = hdr_pos_reg;
        hdr_err_next   = hdr_err_reg;
        phase_next     = phase_reg;
        held_type_next = held_type_reg;
        total_next     = total_reg;
        if (in_accept)
        begin
            if (in_last)
            begin
                hdr_pos_next   = 4'd0;
                hdr_err_next   = rcsp_pkg::ST_OK;
                phase_next     = 1'b0;
                held_type_next = 8'd0;
                total_next     = 17'd0;
            end
            else
            begin
                hdr_pos_next   = pos_upd;
                hdr_err_next   = err_upd;
                phase_next     = phase_upd;
                held_type_next = type_upd;
                total_next     = total_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg   <= 4'd0;
            hdr_err_reg   <= rcsp_pkg::ST_OK;
            phase_reg     <= 1'b0;
            held_type_reg <= 8'd0;
            total_reg     <= 17'd0;
        end
        else
        begin
            hdr_pos_reg   <= hdr_pos_next;
            hdr_err_reg   <= hdr_err_next;
            phase_reg     <= phase_next;
            held_type_reg <= held_type_next;
            total_reg     <= total_next;
        end
    end

    // Header position never runs past the header length
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= rcsp_pkg::HDR_LEN_C)
        else $error("header position past header length");

    // A run record only leaves after a full header with no error
    a_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && run_emit) |->
            (hdr_err_reg == rcsp_pkg::ST_OK && hdr_pos_reg == rcsp_pkg::HDR_LEN_C))
        else $error("run record after bad or short header");

    // Pair phase stays low while the header is still arriving
    a_phase_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_pos_reg < rcsp_pkg::HDR_LEN_C) |-> !phase_reg)
        else $error("pair open inside header");

endmodule

// File: rtl/rcsp_out_fifo.sv
// Record queue: takes up to two records a cycle, sends one a cycle while out_ready is high.
`timescale 1ns / 1ps

module rcsp_out_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rcsp_pkg::rec_pair_t wr,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output rcsp_pkg::rec_t      out_rec
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    rcsp_pkg::rec_t mem [DEPTH];

    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wptr_p1;
    logic [PW-1:0] wptr_p2;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign wptr_p1   = ptr_inc(wptr_reg);
    assign wptr_p2   = ptr_inc(wptr_p1);
    assign out_valid = (count_reg != '0);
    assign out_rec   = mem[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= ROOM_MAX);

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
            mem[wptr_reg] <= wr.rec0;
        if (wr.count == 2'd2)
            mem[wptr_p1] <= wr.rec1;
    end

    // Pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg + CW'(wr.count) - CW'(pop);
        unique case (wr.count)
            2'd1:    wptr_next = wptr_p1;
            2'd2:    wptr_next = wptr_p2;
            default: wptr_next = wptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Fill count never exceeds the depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("record queue overflow");

    // Writes arrive only when room was reported
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.count != 2'd0) |-> room)
        else $error("record write without room");

    // A stalled record stays offered and unchanged
    a_hold_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_rec)))
        else $error("stalled record dropped or changed");

endmodule

// File: rtl/rle_chunk_stream_parser_core.sv
// Top level of the run-length chunk stream parser.
`timescale 1ns / 1ps

// Chunk stream parser.
// Input stream s_*: one file byte per request in s_tdata[7:0]; s_tlast marks
// the last byte of a file. Output stream m_*: one record per request.
// m_tuser is the record kind (0 run, 1 status); m_tlast is set on the status
// record that closes the file. Runs are sent before the status, so a consumer
// drops them when the status is not ok.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 version,
// 1..3 X/Y/Z bit counts, 4 expected block total); write only while idle.
// With the queue empty, the first record of an accepted byte is registered in
// the queue and offered on m_* from there. Throughput: one byte per cycle
// while s_tready is high. A byte makes zero, one or two records, and the
// record queue (QUEUE_DEPTH entries) sends one per cycle while m_tready is
// high; s_tready is high while the queue has room for two records.
// Reset clears the parse state, empties the queue and loads the register
// defaults. When the receiver stalls, records wait in the queue and the input
// stops once fewer than two entries are free.
module rle_chunk_stream_parser_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // Byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // is_final_byte
    // Record output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [7:0] block_type, [24:8] start_index,
                                     // [32:25] run_length, [36:33] status
    output logic        m_tuser,     // result_kind
    output logic        m_tlast      // final_flag
);

    rcsp_pkg::rec_pair_t recs;
    rcsp_pkg::rec_t      out_rec;
    logic                room;
    logic                in_accept;

    assign s_tready  = room;
    assign in_accept = s_tvalid && room;

    // Per-byte parsing
    rcsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .recs      (recs)
    );

    // Record queue toward the consumer
    rcsp_out_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (recs),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    // Output packing
    assign m_tdata = {3'd0, out_rec.status, out_rec.run_length,
                      out_rec.start_index, out_rec.block_type};
    assign m_tuser = out_rec.result_kind;
    assign m_tlast = out_rec.final_flag;

endmodule
